// File: sv/swpsc_pkg.sv
// Shared types and codes for the sliding window pair-sum checker.
`default_nettype none

package swpsc_pkg;

  localparam int VALUE_W = 64;
  localparam int CFG_LEN_W = 6;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RESET = 6'd25;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_FILL    = 2'd0;
  localparam status_t STATUS_VALID   = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;

  // Register indexes of the configuration port
  localparam int REG_WINDOW_LENGTH = 0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      first;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // What the read issued last cycle was for
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_A,
    TAG_B
  } rd_tag_t;

endpackage

`default_nettype wire

// File: sv/swpsc_if.sv
// Item channel interfaces: input values and result status.
`default_nettype none

interface swpsc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [swpsc_pkg::VALUE_W-1:0]   value;
  logic                                   first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

interface swpsc_out_if;
  logic                     valid;
  logic                     ready;
  swpsc_pkg::status_t       status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// File: sv/sliding_window_pair_sum_check.sv
// Top level of the sliding window pair-sum checker: config port, channels, result register.
`default_nettype none

// Each input item carries a signed 64-bit value and a first flag. The block keeps the
// last L values (L = window_length clamped to 2..WINDOW_MAX) in a ring held in a
// single-port synchronous memory. One status item comes back per input item: filling
// while fewer than L values are stored since the last first flag, otherwise valid if
// two stored values that differ sum exactly (65-bit) to the new value, else invalid.
// The new value is then written to the ring, replacing the oldest entry.
// A filling item goes from IDLE straight to FIN, where its result is offered. A checked
// item walks all L*(L-1)/2 pairs, one pair per cycle, plus one read per outer index for
// the first operand, then passes DRAIN for the last compare before FIN. The single memory
// read port sets the pace of the search. A result waits in the output register without
// holding up acceptance of the next item.
// window_length sits at byte address 0 (6 bits, reset 25). No clearing pass: entries
// are only read after being written since the last restart.

module sliding_window_pair_sum_check #(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  swpsc_in_if.sink           in_ch,
  swpsc_out_if.source        out_ch,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CW    = (LEN_W > swpsc_pkg::CFG_LEN_W) ? LEN_W : swpsc_pkg::CFG_LEN_W;

  logic [swpsc_pkg::CFG_LEN_W-1:0] window_length_r;
  logic                            reg_sel;
  logic [CW-1:0]                   wl;
  logic [LEN_W-1:0]                len_eff;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(swpsc_pkg::REG_WINDOW_LENGTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= swpsc_pkg::WINDOW_LENGTH_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      window_length_r <= pwdata[swpsc_pkg::CFG_LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(window_length_r) : '0;

  // clamp the programmed length into 2..WINDOW_MAX
  always_comb begin
    wl = CW'(window_length_r);
    if (wl < CW'(2)) begin
      len_eff = LEN_W'(2);
    end else if (wl > CW'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = wl[LEN_W-1:0];
    end
  end

  // ---- core ----
  swpsc_pkg::job_t    job;
  logic               res_valid;
  logic               res_ready;
  swpsc_pkg::status_t res_status;

  assign job.value = in_ch.value;
  assign job.first = in_ch.first;

  swpsc_core #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (in_ch.valid),
    .job_ready  (in_ch.ready),
    .job        (job),
    .len        (len_eff),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status)
  );

  // ---- result register: decouples the core from a stalled sink ----
  logic               out_valid_r;
  swpsc_pkg::status_t out_status_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;

endmodule

`default_nettype wire

// File: sv/swpsc_core.sv
// Window memory and pair-search sequencer.
`default_nettype none

module swpsc_core #(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    job_valid,
  output logic                                         job_ready,
  input  wire swpsc_pkg::job_t                         job,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]         len,
  output logic                                         res_valid,
  input  wire logic                                    res_ready,
  output swpsc_pkg::status_t                           res_status
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int SW    = LEN_W + 1;
  localparam int VW    = swpsc_pkg::VALUE_W;

  // ring slot of the k-th newest entry, k = 1 is newest
  function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] p,
                                                 input logic [LEN_W-1:0] k);
    logic [SW-1:0] pp;
    logic [SW-1:0] kk;
    logic [SW-1:0] s;
    pp = SW'(p);
    kk = SW'(k);
    if (kk > pp) begin
      s = pp + SW'(WINDOW_MAX) - kk;
    end else begin
      s = pp - kk;
    end
    return s[PTR_W-1:0];
  endfunction

  logic [VW-1:0] mem [WINDOW_MAX];

  swpsc_pkg::state_t   st_r, st_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    j_r, j_nxt;
  logic [LEN_W-1:0]    k_r, k_nxt;
  logic [VW-1:0]       val_r, val_nxt;
  logic                found_r, found_nxt;
  swpsc_pkg::status_t  status_r, status_nxt;
  swpsc_pkg::rd_tag_t  rd_tag_r, rd_tag;
  logic [VW-1:0]       rd_data_r;
  logic [VW-1:0]       a_r;
  logic [PTR_W-1:0]    rd_addr;
  logic                rd_en;
  logic                wr_en;
  logic                hit;
  logic [VW:0]         pair_sum;

  // one pair compared per cycle against the registered first operand
  assign pair_sum = {a_r[VW-1], a_r} + {rd_data_r[VW-1], rd_data_r};
  assign hit = (rd_tag_r == swpsc_pkg::TAG_B) && (a_r != rd_data_r) &&
               (pair_sum == {val_r[VW-1], val_r});

  always_comb begin
    logic [LEN_W-1:0] fill_e;
    logic [PTR_W-1:0] ptr_e;
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    len_nxt    = len_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    val_nxt    = val_r;
    found_nxt  = found_r | hit;
    status_nxt = status_r;
    rd_tag     = swpsc_pkg::TAG_NONE;
    rd_addr    = slot_back(ptr_r, k_r);
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    job_ready  = 1'b0;
    res_valid  = 1'b0;
    fill_e     = job.first ? '0 : fill_r;
    ptr_e      = job.first ? '0 : ptr_r;
    case (st_r)
      swpsc_pkg::ST_IDLE: begin
        job_ready = 1'b1;
        found_nxt = 1'b0;
        if (job_valid) begin
          fill_nxt = fill_e;
          ptr_nxt  = ptr_e;
          val_nxt  = job.value;
          len_nxt  = len;
          j_nxt    = LEN_W'(1);
          if (fill_e < len) begin
            status_nxt = swpsc_pkg::STATUS_FILL;
            st_nxt     = swpsc_pkg::ST_FIN;
          end else begin
            st_nxt = swpsc_pkg::ST_RD_A;
          end
        end
      end
      swpsc_pkg::ST_RD_A: begin
        rd_en   = 1'b1;
        rd_tag  = swpsc_pkg::TAG_A;
        rd_addr = slot_back(ptr_r, j_r);
        k_nxt   = j_r + LEN_W'(1);
        st_nxt  = swpsc_pkg::ST_RD_B;
      end
      swpsc_pkg::ST_RD_B: begin
        rd_en   = 1'b1;
        rd_tag  = swpsc_pkg::TAG_B;
        rd_addr = slot_back(ptr_r, k_r);
        if (k_r == len_r) begin
          if (j_r == len_r - LEN_W'(1)) begin
            st_nxt = swpsc_pkg::ST_DRAIN;
          end else begin
            j_nxt  = j_r + LEN_W'(1);
            st_nxt = swpsc_pkg::ST_RD_A;
          end
        end else begin
          k_nxt = k_r + LEN_W'(1);
        end
      end
      swpsc_pkg::ST_DRAIN: begin
        // last compare lands this cycle
        status_nxt = (found_r | hit) ? swpsc_pkg::STATUS_VALID
                                     : swpsc_pkg::STATUS_INVALID;
        st_nxt     = swpsc_pkg::ST_FIN;
      end
      swpsc_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          wr_en    = 1'b1;
          ptr_nxt  = (ptr_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_r + PTR_W'(1);
          fill_nxt = (fill_r == LEN_W'(WINDOW_MAX)) ? fill_r : fill_r + LEN_W'(1);
          st_nxt   = swpsc_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = swpsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= swpsc_pkg::ST_IDLE;
      fill_r   <= '0;
      ptr_r    <= '0;
      rd_tag_r <= swpsc_pkg::TAG_NONE;
      found_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
      ptr_r    <= ptr_nxt;
      rd_tag_r <= rd_tag;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    if (rd_tag_r == swpsc_pkg::TAG_A) begin
      a_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: dv/swpsc_status_checker.sv
// Status checker: watches the channels and config port, predicts each status, compares.
`default_nettype none

module swpsc_status_checker #(
  parameter int WINDOW_MAX = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  swpsc_in_if              in_ch,
  swpsc_out_if             out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               outstanding
);

  logic [swpsc_pkg::VALUE_W-1:0]   ring [WINDOW_MAX];
  int unsigned                     stored;
  int unsigned                     wr_slot;
  logic [swpsc_pkg::CFG_LEN_W-1:0] len_reg;
  swpsc_pkg::status_t              status_due [$];
  swpsc_pkg::status_t              due;

  function automatic int unsigned clamp_len(logic [swpsc_pkg::CFG_LEN_W-1:0] r);
    if (r < 2) return 2;
    if (r > WINDOW_MAX) return WINDOW_MAX;
    return r;
  endfunction

  // k-th most recent entry, k = 1 is the newest
  function automatic logic [swpsc_pkg::VALUE_W-1:0] entry_back(int unsigned k);
    return ring[(wr_slot + WINDOW_MAX - k) % WINDOW_MAX];
  endfunction

  // Two different entries among the last len whose exact sum is target
  function automatic bit pair_found(int unsigned len,
                                    logic [swpsc_pkg::VALUE_W-1:0] target);
    logic [swpsc_pkg::VALUE_W-1:0] a;
    logic [swpsc_pkg::VALUE_W-1:0] b;
    logic [swpsc_pkg::VALUE_W:0]   sum;
    for (int unsigned j = 1; j <= len; j++) begin
      a = entry_back(j);
      for (int unsigned k = j + 1; k <= len; k++) begin
        b = entry_back(k);
        sum = {a[swpsc_pkg::VALUE_W-1], a} + {b[swpsc_pkg::VALUE_W-1], b};
        if (a != b && sum == {target[swpsc_pkg::VALUE_W-1], target}) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Status of one item; updates the window as the block does
  function automatic swpsc_pkg::status_t window_status(logic [swpsc_pkg::VALUE_W-1:0] v,
                                                       logic first);
    int unsigned        len;
    swpsc_pkg::status_t st;
    len = clamp_len(len_reg);
    if (first) begin
      stored  = 0;
      wr_slot = 0;
    end
    if (stored < len) st = swpsc_pkg::STATUS_FILL;
    else st = pair_found(len, v) ? swpsc_pkg::STATUS_VALID : swpsc_pkg::STATUS_INVALID;
    ring[wr_slot] = v;
    wr_slot = (wr_slot + 1) % WINDOW_MAX;
    if (stored < WINDOW_MAX) stored++;
    return st;
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored     = 0;
      wr_slot    = 0;
      len_reg    = swpsc_pkg::WINDOW_LENGTH_RESET;
      fail_count = 0;
      status_due.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == 3'(4 * swpsc_pkg::REG_WINDOW_LENGTH))
        len_reg = pwdata[swpsc_pkg::CFG_LEN_W-1:0];
      // results first, so a stray one cannot pair with an item taken this edge
      if (out_ch.valid && out_ch.ready) begin
        if (status_due.size() == 0) begin
          note_failure($sformatf("unexpected status item %0d", out_ch.status));
        end else begin
          due = status_due[0];
          status_due.delete(0);
          if (out_ch.status !== due)
            note_failure($sformatf("status mismatch: expected %0d, got %0d",
                                   due, out_ch.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        status_due.insert(status_due.size(), window_status(in_ch.value, in_ch.first));
    end
    outstanding = status_due.size();
  end

endmodule

`default_nettype wire

// File: dv/tb_sliding_window_pair_sum_check.sv
// Testbench top: clock, reset, stimulus, idling, watchdog and verdict for the pair-sum checker.
`default_nettype none

module tb_sliding_window_pair_sum_check;

  localparam int WINDOW_MAX    = 32;
  localparam int ITEMS_PER_SET = 37;  // 12 random sets, about 440 items
  localparam int HOLD_CYCLES   = 1200;
  // IDLE_LIMIT covers a checked item at full length plus the result-side hold-off.
  localparam int IDLE_LIMIT    = 8000;
  localparam int DRAIN_CYCLES  = 600;

  localparam logic [swpsc_pkg::VALUE_W-1:0] V_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [swpsc_pkg::VALUE_W-1:0] V_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [swpsc_pkg::VALUE_W-1:0] V_ONES = '1;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;

  // idle percentages, changed between sets
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  // stimulus-side view of the stream, used only to aim sums at live entries
  logic [swpsc_pkg::VALUE_W-1:0] sent_hist [$];
  int unsigned                   cur_len;

  swpsc_in_if  in_ch ();
  swpsc_out_if out_ch ();

  sliding_window_pair_sum_check #(
    .WINDOW_MAX(WINDOW_MAX)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swpsc_status_checker #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off on request so that the
  // result register stays full and the block backs up into its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any item, result or register access resets the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end while (idle_cycles < IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned clamp_len(int unsigned r);
    if (r < 2) return 2;
    if (r > WINDOW_MAX) return WINDOW_MAX;
    return r;
  endfunction

  // About half are sums of two live entries so the valid path gets exercised; the rest
  // is full-range noise, small values (repeats, equal pairs) and extremes.
  function automatic logic [swpsc_pkg::VALUE_W-1:0] pick_value();
    int unsigned                   span;
    int unsigned                   j;
    int unsigned                   k;
    int unsigned                   roll;
    logic [swpsc_pkg::VALUE_W-1:0] v;
    span = clamp_len(cur_len);
    if (span > sent_hist.size()) span = sent_hist.size();
    roll = $urandom_range(99);
    if (span >= 2 && roll < 50) begin
      j = $urandom_range(span - 1);
      do k = $urandom_range(span - 1); while (k == j);
      v = sent_hist[sent_hist.size() - 1 - j] + sent_hist[sent_hist.size() - 1 - k];
    end else if (roll < 70) begin
      v = {$urandom, $urandom};
    end else if (roll < 85) begin
      v = 64'($signed($urandom_range(16)) - 8);
    end else begin
      case ($urandom_range(3))
        0:       v = V_MAX;
        1:       v = V_MIN;
        2:       v = '0;
        default: v = V_ONES;
      endcase
    end
    return v;
  endfunction

  // Offer one item; starts and ends on a falling edge. valid stays high after
  // acceptance so back-to-back items need no drop.
  task automatic push_item(logic [swpsc_pkg::VALUE_W-1:0] v, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.first <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (first) sent_hist.delete();
    sent_hist.insert(sent_hist.size(), v);
    if (sent_hist.size() > WINDOW_MAX) sent_hist.delete(0);
    @(negedge clk);
  endtask

  // Stop offering and wait until every status has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Two-phase register write; upper data bits are don't-care and get noise.
  task automatic write_window_length(int unsigned len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * swpsc_pkg::REG_WINDOW_LENGTH);
    pwdata  <= {26'($urandom >> 6), 6'(len)};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_len = len;
  endtask

  initial begin
    // lengths per random set: reset value, both sides of each clamp, extremes
    int unsigned set_len [12];

    set_len       = '{25, 0, 32, 7, 1, 63, 3, 33, 2, 16, 32, 12};
    hold_req      = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 66;
    cur_len       = swpsc_pkg::WINDOW_LENGTH_RESET;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.first   <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the minimum length, where each check sees exactly
    // the two previous values.
    write_window_length(2);
    push_item(V_MAX, 1'b1);     // filling
    push_item(64'd1, 1'b0);     // filling
    push_item(V_MIN, 1'b0);     // max + 1 overflows: must not match min
    push_item(V_MIN + 1, 1'b0); // 1 + min: genuine match
    push_item(64'd1, 1'b0);     // min + (min+1) wraps to 1: no match
    push_item(64'd5, 1'b0);
    push_item(64'd5, 1'b0);
    push_item(64'd10, 1'b0);    // 5 + 5 from equal entries never pairs
    push_item(V_ONES, 1'b1);    // restart mid-stream: back to filling
    push_item(64'd0, 1'b0);
    push_item(V_ONES, 1'b0);    // -1 + 0
    push_item(V_MIN, 1'b0);
    push_item(V_MAX, 1'b0);     // min + (-1) wraps to max: no match
    push_item(V_ONES, 1'b0);    // min + max = -1
    push_item(64'd0, 1'b0);
    push_item(64'd0, 1'b1);     // restart with zero
    push_item(V_MAX, 1'b0);
    push_item(V_MAX, 1'b0);     // 0 + max
    settle();

    // Random sets. No first flag forced after a length change, so new
    // lengths also take effect mid-stream.
    for (int s = 0; s < 12; s++) begin
      if (s < 4) begin
        send_idle_pct = 27;
        recv_idle_pct = 66;
      end else if (s < 8) begin
        send_idle_pct = 66;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_window_length(set_len[s]);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        // long result-side hold-off while items keep coming
        if ((s == 1 || s == 9) && n == 10) hold_req = 1'b1;
        // sender pause until everything is back
        if ((s == 5 || s == 10) && n == 20) settle();
        push_item(pick_value(), ($urandom_range(99) < 3));
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sliding_window_pair_sum_check.f
sv/swpsc_pkg.sv
sv/swpsc_if.sv
sv/swpsc_core.sv
sv/sliding_window_pair_sum_check.sv
dv/swpsc_status_checker.sv
dv/tb_sliding_window_pair_sum_check.sv
